[sv/wss_pkg.sv]
`timescale 1ns / 1ps
package wss_pkg;

    localparam int ENTRIES_DEFAULT = 16;

    localparam int OP_W          = 1;
    localparam int ENTRY_INDEX_W = 4;
    localparam int SECONDS_W     = 17;
    localparam int DAYS_W        = 7;
    localparam int TEMP_W        = 8;
    localparam int WEEKDAY_W     = 3;
    localparam int HOUR_W        = 5;
    localparam int MINUTE_W      = 6;
    localparam int SECOND_W      = 6;
    localparam int SEL_W         = 4;

    localparam int SEC_PER_HOUR = 3600;
    localparam int SEC_PER_MIN  = 60;
    localparam int DAY_SECONDS  = 24 * 3600;

    localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
    localparam logic [OP_W-1:0] OP_TIME = 1'b1;

    typedef struct packed {
        logic [TEMP_W-1:0]    temperature;
        logic [DAYS_W-1:0]    days;
        logic [SECONDS_W-1:0] seconds;
    } entry_t;

    typedef struct packed {
        logic clear;
        logic check;
    } best_ctrl_t;

endpackage

[sv/wss_ram.sv]
`timescale 1ns / 1ps
module wss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/wss_best.sv]
`timescale 1ns / 1ps
module wss_best #(
    parameter int IDX_W = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  wss_pkg::best_ctrl_t            ctrl,
    input  logic [IDX_W-1:0]               cand_idx,
    input  wss_pkg::entry_t                cand_entry,
    input  logic [wss_pkg::SECONDS_W-1:0]  now,
    input  logic [wss_pkg::WEEKDAY_W-1:0]  wday,
    output logic                           found,
    output logic [IDX_W-1:0]               best_idx,
    output logic [wss_pkg::TEMP_W-1:0]     best_temp
);
    import wss_pkg::*;

    logic                 found_reg, found_next;
    logic [SECONDS_W-1:0] gap_reg, gap_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [TEMP_W-1:0]    temp_reg, temp_next;

    logic [DAYS_W:0]    days_ext;
    logic [SECONDS_W:0] gap;
    logic               day_hit;
    logic               better;

    always_comb begin
        days_ext = {1'b0, cand_entry.days};
        day_hit  = days_ext[wday];
        gap      = {1'b0, now} - {1'b0, cand_entry.seconds};
        better   = !gap[SECONDS_W] && (gap[SECONDS_W-1:0] != '0)
                   && (gap[SECONDS_W-1:0] < gap_reg);

        found_next = found_reg;
        gap_next   = gap_reg;
        idx_next   = idx_reg;
        temp_next  = temp_reg;
        if (ctrl.clear) begin
            found_next = 1'b0;
            gap_next   = SECONDS_W'(DAY_SECONDS);
        end else if (ctrl.check && day_hit && better) begin
            found_next = 1'b1;
            gap_next   = gap[SECONDS_W-1:0];
            idx_next   = cand_idx;
            temp_next  = cand_entry.temperature;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
            gap_reg   <= SECONDS_W'(DAY_SECONDS);
        end else begin
            found_reg <= found_next;
            gap_reg   <= gap_next;
        end
        idx_reg  <= idx_next;
        temp_reg <= temp_next;
    end

    assign found     = found_reg;
    assign best_idx  = idx_reg;
    assign best_temp = temp_reg;

endmodule

[sv/weekly_setpoint_schedule.sv]
`timescale 1ns / 1ps
// Load item: sets or clears the entry's valid bit, writes the entry memory when enabled, no result.
// Time item: one entry memory read per cycle while scanning; the next item is taken only
// after the result has entered the output register, which waits while that register is full.
// The rate is set by the single read port of the entry memory.
// Reset clears all valid bits, the active-entry flag and the output valid flag; entry data is
// left as is; a scan reads it but only uses entries whose valid bit is set.
module weekly_setpoint_schedule #(
    parameter int ENTRIES = wss_pkg::ENTRIES_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [wss_pkg::OP_W-1:0]           s_op,
    input  logic [wss_pkg::ENTRY_INDEX_W-1:0]  s_entry_index,
    input  logic [wss_pkg::SECONDS_W-1:0]      s_entry_seconds,
    input  logic [wss_pkg::DAYS_W-1:0]         s_entry_days,
    input  logic [wss_pkg::TEMP_W-1:0]         s_entry_temperature,
    input  logic                               s_entry_enable,
    input  logic [wss_pkg::WEEKDAY_W-1:0]      s_weekday,
    input  logic [wss_pkg::HOUR_W-1:0]         s_hour,
    input  logic [wss_pkg::MINUTE_W-1:0]       s_minute,
    input  logic [wss_pkg::SECOND_W-1:0]       s_second,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_changed,
    output logic [wss_pkg::TEMP_W-1:0]         m_temperature,
    output logic                               m_found,
    output logic [wss_pkg::SEL_W-1:0]          m_selected_index
);
    import wss_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(ENTRIES);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    logic [SECONDS_W-1:0] now_reg, now_next;
    logic [WEEKDAY_W-1:0] wday_reg, wday_next;
    logic [ENTRIES-1:0]   valid_reg, valid_next;
    logic                 active_vld_reg, active_vld_next;
    logic [IDX_W-1:0]     active_idx_reg, active_idx_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 changed_reg, changed_next;
    logic [TEMP_W-1:0]    temp_reg, temp_next;
    logic                 found_reg, found_next;
    logic [SEL_W-1:0]     sel_reg, sel_next;

    logic             accept;
    logic             slot_ok;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;
    best_ctrl_t       best_ctrl;
    logic             best_found;
    logic [IDX_W-1:0] best_idx;
    logic [TEMP_W-1:0] best_temp;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign slot_ok = (32'(s_entry_index) < ENTRIES);

    assign wr_en   = accept && (s_op == OP_LOAD) && slot_ok && s_entry_enable;
    assign wr_addr = IDX_W'(s_entry_index);
    assign wr_data = '{temperature: s_entry_temperature, days: s_entry_days,
                       seconds: s_entry_seconds};
    assign rd_en   = (state_reg == ST_SCAN) && (cnt_reg != CNT_END);
    assign rd_addr = cnt_reg[IDX_W-1:0];

    assign best_ctrl.clear = accept && (s_op == OP_TIME);
    assign best_ctrl.check = (state_reg == ST_SCAN) && pend_vld_reg && valid_reg[pend_idx_reg];

    wss_ram #(
        .WIDTH  ($bits(entry_t)),
        .DEPTH  (ENTRIES),
        .ADDR_W (IDX_W)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    wss_best #(
        .IDX_W (IDX_W)
    ) u_best (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (best_ctrl),
        .cand_idx   (pend_idx_reg),
        .cand_entry (rd_data),
        .now        (now_reg),
        .wday       (wday_reg),
        .found      (best_found),
        .best_idx   (best_idx),
        .best_temp  (best_temp)
    );

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pend_vld_next   = pend_vld_reg;
        pend_idx_next   = pend_idx_reg;
        now_next        = now_reg;
        wday_next       = wday_reg;
        valid_next      = valid_reg;
        active_vld_next = active_vld_reg;
        active_idx_next = active_idx_reg;
        m_valid_next    = m_valid_reg;
        changed_next    = changed_reg;
        temp_next       = temp_reg;
        found_next      = found_reg;
        sel_next        = sel_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_op == OP_TIME) begin
                        now_next = SECONDS_W'({12'd0, s_hour}) * SECONDS_W'(SEC_PER_HOUR)
                                 + SECONDS_W'({11'd0, s_minute}) * SECONDS_W'(SEC_PER_MIN)
                                 + SECONDS_W'({11'd0, s_second});
                        wday_next     = s_weekday;
                        cnt_next      = '0;
                        pend_vld_next = 1'b0;
                        state_next    = ST_SCAN;
                    end else if (slot_ok) begin
                        valid_next[IDX_W'(s_entry_index)] = s_entry_enable;
                    end
                end
            end
            ST_SCAN: begin
                // issue one read per cycle, evaluate it the cycle after
                if (cnt_reg != CNT_END) begin
                    cnt_next      = cnt_reg + 1'b1;
                    pend_vld_next = 1'b1;
                    pend_idx_next = cnt_reg[IDX_W-1:0];
                end else begin
                    pend_vld_next = 1'b0;
                    if (!pend_vld_reg) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    found_next   = best_found;
                    changed_next = best_found
                                   && (!active_vld_reg || (best_idx != active_idx_reg));
                    temp_next    = best_found ? best_temp : '0;
                    sel_next     = best_found ? SEL_W'(best_idx) : '0;
                    if (best_found) begin
                        active_vld_next = 1'b1;
                        active_idx_next = best_idx;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            pend_vld_reg   <= 1'b0;
            valid_reg      <= '0;
            active_vld_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pend_vld_reg   <= pend_vld_next;
            valid_reg      <= valid_next;
            active_vld_reg <= active_vld_next;
            m_valid_reg    <= m_valid_next;
        end
        pend_idx_reg   <= pend_idx_next;
        now_reg        <= now_next;
        wday_reg       <= wday_next;
        active_idx_reg <= active_idx_next;
        changed_reg    <= changed_next;
        temp_reg       <= temp_next;
        found_reg      <= found_next;
        sel_reg        <= sel_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_changed        = changed_reg;
    assign m_temperature    = temp_reg;
    assign m_found          = found_reg;
    assign m_selected_index = sel_reg;

    a_time_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_op == OP_TIME)) |=> (state_reg == ST_SCAN))
        else $error("time item did not start a scan");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_op == OP_LOAD) && !m_valid_reg) |=> !m_valid_reg)
        else $error("load item produced a result");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result raised outside finish");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_END)
        else $error("scan counter out of range");

    a_none_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !found_reg) |-> (!changed_reg && (temp_reg == '0) && (sel_reg == '0)))
        else $error("empty result carries data");

endmodule

[tb/weekly_setpoint_schedule_tb.sv]
`timescale 1ns / 1ps
module weekly_setpoint_schedule_tb;
    import wss_pkg::*;

    localparam int N_SLOTS = ENTRIES_DEFAULT;
    localparam int ITEM_CYCLES = N_SLOTS + 4;
    localparam int LIMIT_CYCLES = 400000;
    localparam logic [4:0] NO_SLOT = 5'h1F;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic [ENTRY_INDEX_W-1:0] index;
        logic [SECONDS_W-1:0]     seconds;
        logic [DAYS_W-1:0]        days;
        logic [TEMP_W-1:0]        temperature;
        logic                     enable;
        logic [WEEKDAY_W-1:0]     weekday;
        logic [HOUR_W-1:0]        hour;
        logic [MINUTE_W-1:0]      minute;
        logic [SECOND_W-1:0]      second;
    } sched_item_t;

    typedef struct {
        logic              changed;
        logic [TEMP_W-1:0] temperature;
        logic              found;
        logic [SEL_W-1:0]  slot;
    } setpoint_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [OP_W-1:0] s_op;
    logic [ENTRY_INDEX_W-1:0] s_entry_index;
    logic [SECONDS_W-1:0] s_entry_seconds;
    logic [DAYS_W-1:0] s_entry_days;
    logic [TEMP_W-1:0] s_entry_temperature;
    logic s_entry_enable;
    logic [WEEKDAY_W-1:0] s_weekday;
    logic [HOUR_W-1:0] s_hour;
    logic [MINUTE_W-1:0] s_minute;
    logic [SECOND_W-1:0] s_second;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_changed;
    logic [TEMP_W-1:0] m_temperature;
    logic m_found;
    logic [SEL_W-1:0] m_selected_index;

    entry_t sched_table [N_SLOTS];
    logic sched_valid [N_SLOTS] = '{default: 1'b0};
    logic [4:0] active_slot = NO_SLOT;
    setpoint_t pending_setpoints [$];
    setpoint_t want;

    int mismatch_count = 0;
    int cycle_count = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int snk_hold_left = 0;

    weekly_setpoint_schedule uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_op(s_op),
        .s_entry_index(s_entry_index),
        .s_entry_seconds(s_entry_seconds),
        .s_entry_days(s_entry_days),
        .s_entry_temperature(s_entry_temperature),
        .s_entry_enable(s_entry_enable),
        .s_weekday(s_weekday),
        .s_hour(s_hour),
        .s_minute(s_minute),
        .s_second(s_second),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_changed(m_changed),
        .m_temperature(m_temperature),
        .m_found(m_found),
        .m_selected_index(m_selected_index)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (snk_hold_left > 0) begin
            snk_hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_setpoints.size() == 0) begin
                $error("result item with no expectation waiting");
                mismatch_count++;
            end else begin
                want = pending_setpoints.pop_front();
                if (m_changed !== want.changed) begin
                    $error("changed: expected %0d, got %0d", want.changed, m_changed);
                    mismatch_count++;
                end
                if (m_temperature !== want.temperature) begin
                    $error("temperature: expected %0d, got %0d", want.temperature,
                           m_temperature);
                    mismatch_count++;
                end
                if (m_found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, m_found);
                    mismatch_count++;
                end
                if (m_selected_index !== want.slot) begin
                    $error("selected_index: expected %0d, got %0d", want.slot,
                           m_selected_index);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic apply_to_schedule(input sched_item_t it);
        int now_s;
        int gap;
        int best;
        int best_gap;
        setpoint_t sp;
        if (it.op == OP_LOAD) begin
            if (it.index < N_SLOTS) begin
                if (it.enable) begin
                    sched_table[it.index] = '{temperature: it.temperature, days: it.days,
                                              seconds: it.seconds};
                    sched_valid[it.index] = 1'b1;
                end else begin
                    sched_valid[it.index] = 1'b0;
                end
            end
        end else begin
            now_s = int'(it.hour) * SEC_PER_HOUR + int'(it.minute) * SEC_PER_MIN
                  + int'(it.second);
            best = -1;
            best_gap = DAY_SECONDS;
            for (int i = 0; i < N_SLOTS; i++) begin
                if (sched_valid[i] && it.weekday < DAYS_W) begin
                    if (sched_table[i].days[it.weekday]) begin
                        gap = now_s - int'(sched_table[i].seconds);
                        if (gap > 0 && gap < best_gap) begin
                            best_gap = gap;
                            best = i;
                        end
                    end
                end
            end
            if (best < 0) begin
                sp = '{changed: 1'b0, temperature: '0, found: 1'b0, slot: '0};
            end else begin
                sp.changed = (5'(best) != active_slot);
                sp.temperature = sched_table[best].temperature;
                sp.found = 1'b1;
                sp.slot = SEL_W'(best);
                active_slot = 5'(best);
            end
            pending_setpoints.push_back(sp);
        end
    endtask

    task automatic offer_item(input sched_item_t it);
        int gap_cycles;
        gap_cycles = 0;
        while (gap_cycles < 40 && $urandom_range(99) < src_idle_pct)
            gap_cycles++;
        if (gap_cycles > 0) begin
            s_valid <= 1'b0;
            repeat (gap_cycles) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= it.op;
        s_entry_index <= it.index;
        s_entry_seconds <= it.seconds;
        s_entry_days <= it.days;
        s_entry_temperature <= it.temperature;
        s_entry_enable <= it.enable;
        s_weekday <= it.weekday;
        s_hour <= it.hour;
        s_minute <= it.minute;
        s_second <= it.second;
        do @(posedge aclk); while (!s_ready);
        apply_to_schedule(it);
    endtask

    function automatic sched_item_t noise_item();
        sched_item_t it;
        it.op = OP_W'($urandom);
        it.index = ENTRY_INDEX_W'($urandom);
        it.seconds = SECONDS_W'($urandom);
        it.days = DAYS_W'($urandom);
        it.temperature = TEMP_W'($urandom);
        it.enable = 1'($urandom);
        it.weekday = WEEKDAY_W'($urandom);
        it.hour = HOUR_W'($urandom);
        it.minute = MINUTE_W'($urandom);
        it.second = SECOND_W'($urandom);
        return it;
    endfunction

    function automatic sched_item_t load_item(input int slot, input int secs, input int days,
                                              input int temp, input bit en);
        sched_item_t it;
        it = noise_item();
        it.op = OP_LOAD;
        it.index = ENTRY_INDEX_W'(slot);
        it.seconds = SECONDS_W'(secs);
        it.days = DAYS_W'(days);
        it.temperature = TEMP_W'(temp);
        it.enable = en;
        return it;
    endfunction

    function automatic sched_item_t time_item(input int wd, input int h, input int m,
                                              input int s);
        sched_item_t it;
        it = noise_item();
        it.op = OP_TIME;
        it.weekday = WEEKDAY_W'(wd);
        it.hour = HOUR_W'(h);
        it.minute = MINUTE_W'(m);
        it.second = SECOND_W'(s);
        return it;
    endfunction

    function automatic sched_item_t random_item();
        int pick;
        int secs;
        pick = $urandom_range(99);
        if (pick < 30) begin
            if ($urandom_range(1))
                secs = $urandom_range(23) * SEC_PER_HOUR;
            else
                secs = $urandom_range(DAY_SECONDS - 1);
            return load_item($urandom_range(N_SLOTS - 1), secs, $urandom_range(127, 1),
                             $urandom_range(255), $urandom_range(99) < 85);
        end else if (pick < 92) begin
            return time_item($urandom_range(6), $urandom_range(23), $urandom_range(59),
                             $urandom_range(59));
        end
        return noise_item();
    endfunction

    task automatic test_directed();
        src_idle_pct = 0;
        snk_stall_pct = 0;
        offer_item(time_item(3, 12, 0, 0));
        offer_item(load_item(0, 0, 7'h7F, 0, 1'b1));
        offer_item(load_item(15, DAY_SECONDS - 1, 7'h01, 255, 1'b1));
        offer_item(time_item(0, 0, 0, 0));
        offer_item(time_item(0, 0, 0, 1));
        offer_item(time_item(0, 0, 0, 2));
        offer_item(load_item(5, SEC_PER_HOUR, 7'h40, 200, 1'b1));
        offer_item(load_item(3, SEC_PER_HOUR, 7'h40, 100, 1'b1));
        offer_item(time_item(6, 1, 0, 1));
        offer_item(time_item(7, 23, 59, 59));
        offer_item(time_item(0, 24, 0, 0));
        offer_item(load_item(3, 0, 0, 0, 1'b0));
        offer_item(time_item(6, 1, 0, 1));
        offer_item(load_item(3, 100000, 7'h7F, 77, 1'b1));
        offer_item(time_item(1, 31, 63, 63));
        offer_item(load_item(7, 0, 0, 0, 1'b0));
        offer_item(load_item(9, 131071, 7'h7F, 255, 1'b1));
        offer_item(time_item(1, 12, 0, 0));
        offer_item(time_item(6, 0, 30, 0));
    endtask

    task automatic test_random_phase(input int n_items, input int idle_pct,
                                     input int stall_pct);
        src_idle_pct = idle_pct;
        snk_stall_pct = stall_pct;
        repeat (n_items) offer_item(random_item());
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_stall_pct = 0;
        // hold the result side long enough for the input to back up
        snk_hold_left = 400;
        repeat (12) offer_item(random_item());
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_op <= OP_LOAD;
        s_entry_index <= '0;
        s_entry_seconds <= '0;
        s_entry_days <= '0;
        s_entry_temperature <= '0;
        s_entry_enable <= 1'b0;
        s_weekday <= '0;
        s_hour <= '0;
        s_minute <= '0;
        s_second <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_phase(135, 0, 0);
        test_random_phase(135, 80, 0);
        test_backpressure();
        test_random_phase(135, 0, 80);
        test_random_phase(135, 28, 28);

        s_valid <= 1'b0;
        while (pending_setpoints.size() != 0) @(posedge aclk);
        repeat (ITEM_CYCLES * 2) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
